@@ design/quoted_argument_tokenizer_top_macros.svh @@
// ----------------------------------------------------------------------------
// quoted argument tokenizer assertion macros
// clocked checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef QUOTED_ARGUMENT_TOKENIZER_TOP_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition holds at every clock edge
`define QAT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent implies consequent on the following edge
`define QAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QAT_ASSERT_ALWAYS(lbl, cond, msg)
`define QAT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/qat_pkg.sv @@
// ----------------------------------------------------------------------------
// qat_pkg
// shared types and character constants of the argument tokenizer
// ----------------------------------------------------------------------------
package qat_pkg;

    // character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // most results one input word can cause
    localparam int unsigned MAX_RES = 3;

    // result kinds
    typedef enum logic [2:0] {
        KIND_BYTE  = 3'd0,
        KIND_END   = 3'd1,
        KIND_BADQ  = 3'd2,
        KIND_OPENQ = 3'd3,
        KIND_ESC   = 3'd4
    } kind_t;

    // all results of one input word, as passed from front to back
    typedef struct packed {
        logic [1:0]                  cnt;
        logic                        last;
        kind_t [MAX_RES-1:0]         kind;
        logic [MAX_RES-1:0][7:0]     tbyte;
        logic [MAX_RES-1:0][15:0]    total;
    } bundle_t;

endpackage

@@ design/qat_front.sv @@
// ----------------------------------------------------------------------------
// qat_front
// classifies each input byte against the quoting state and builds the
// bundle of results it causes
// ----------------------------------------------------------------------------
`include "quoted_argument_tokenizer_top_macros.svh"

module qat_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [7:0]        text_byte,
    input  logic              string_last,
    output qat_pkg::bundle_t  bundle
);

    typedef struct packed {
        logic        inside_token;
        logic        inside_quotes;
        logic        quote_is_double;
        logic        escape_pending;
        logic        held_backslash;
        logic        error_seen;
        logic [15:0] token_count;
    } front_state_t;

    front_state_t st_reg;
    front_state_t st_next;

    // append one result to a bundle
    function automatic qat_pkg::bundle_t add_result(input qat_pkg::bundle_t bd,
                                                    input qat_pkg::kind_t k,
                                                    input logic [7:0] b,
                                                    input logic [15:0] tot);
        qat_pkg::bundle_t r;
        r = bd;
        if (r.cnt != 2'd3)
        begin
            r.kind[r.cnt]  = k;
            r.tbyte[r.cnt] = b;
            r.total[r.cnt] = tot;
            r.cnt          = r.cnt + 2'd1;
        end
        return r;
    endfunction

    // byte classification and state update
    always_comb
    begin
        front_state_t     st;
        qat_pkg::bundle_t bd;
        logic [7:0]       match;
        logic             consumed;

        st       = st_reg;
        bd       = '0;
        bd.last  = string_last;
        match    = st_reg.quote_is_double ? qat_pkg::CH_DQUOTE : qat_pkg::CH_SQUOTE;
        consumed = 1'b0;

        if (!st.error_seen && text_byte != qat_pkg::CH_LF)
        begin
            // backslash held inside quotes resolves against this byte
            if (st.held_backslash)
            begin
                st.held_backslash = 1'b0;
                if (text_byte == match)
                begin
                    bd       = add_result(bd, qat_pkg::KIND_BYTE, text_byte, st.token_count);
                    consumed = 1'b1;
                end
                else
                begin
                    bd = add_result(bd, qat_pkg::KIND_BYTE, qat_pkg::CH_BSLASH,
                                    st.token_count);
                end
            end

            if (!consumed)
            begin
                if (text_byte == qat_pkg::CH_SPACE || text_byte == qat_pkg::CH_TAB)
                begin
                    // blank: escaped, inside quotes, or token separator
                    if (st.escape_pending)
                    begin
                        st.escape_pending = 1'b0;
                        st.inside_token   = 1'b1;
                        bd = add_result(bd, qat_pkg::KIND_BYTE, text_byte, st.token_count);
                    end
                    else if (st.inside_token)
                    begin
                        if (st.inside_quotes)
                        begin
                            bd = add_result(bd, qat_pkg::KIND_BYTE, text_byte,
                                            st.token_count);
                        end
                        else
                        begin
                            st.inside_token  = 1'b0;
                            st.inside_quotes = 1'b0;
                            if (st.token_count != 16'hFFFF)
                                st.token_count = st.token_count + 16'd1;
                            bd = add_result(bd, qat_pkg::KIND_END, 8'h00, st.token_count);
                        end
                    end
                end
                else if (text_byte == qat_pkg::CH_DQUOTE || text_byte == qat_pkg::CH_SQUOTE)
                begin
                    // quote: escaped, opening, closing, literal or misplaced
                    if (st.escape_pending)
                    begin
                        st.escape_pending = 1'b0;
                        st.inside_token   = 1'b1;
                        bd = add_result(bd, qat_pkg::KIND_BYTE, text_byte, st.token_count);
                    end
                    else if (!st.inside_token)
                    begin
                        st.inside_token    = 1'b1;
                        st.inside_quotes   = 1'b1;
                        st.quote_is_double = (text_byte == qat_pkg::CH_DQUOTE);
                    end
                    else if (st.inside_quotes)
                    begin
                        if (text_byte == match)
                        begin
                            st.inside_token  = 1'b0;
                            st.inside_quotes = 1'b0;
                            if (st.token_count != 16'hFFFF)
                                st.token_count = st.token_count + 16'd1;
                            bd = add_result(bd, qat_pkg::KIND_END, 8'h00, st.token_count);
                        end
                        else
                        begin
                            bd = add_result(bd, qat_pkg::KIND_BYTE, text_byte,
                                            st.token_count);
                        end
                    end
                    else
                    begin
                        st.error_seen = 1'b1;
                        bd = add_result(bd, qat_pkg::KIND_BADQ, 8'h00, st.token_count);
                    end
                end
                else if (text_byte == qat_pkg::CH_BSLASH)
                begin
                    // backslash: held in quotes, escaped, or starts an escape
                    if (st.inside_quotes)
                        st.held_backslash = 1'b1;
                    else if (st.escape_pending)
                    begin
                        st.escape_pending = 1'b0;
                        st.inside_token   = 1'b1;
                        bd = add_result(bd, qat_pkg::KIND_BYTE, text_byte, st.token_count);
                    end
                    else
                        st.escape_pending = 1'b1;
                end
                else
                begin
                    // ordinary byte
                    st.escape_pending = 1'b0;
                    st.inside_token   = 1'b1;
                    bd = add_result(bd, qat_pkg::KIND_BYTE, text_byte, st.token_count);
                end
            end
        end

        // implied newline at end of string
        if (string_last && !st.error_seen)
        begin
            if (st.held_backslash)
            begin
                st.held_backslash = 1'b0;
                bd = add_result(bd, qat_pkg::KIND_BYTE, qat_pkg::CH_BSLASH, st.token_count);
            end
            if (st.inside_quotes)
            begin
                st.error_seen = 1'b1;
                bd = add_result(bd, qat_pkg::KIND_OPENQ, 8'h00, st.token_count);
            end
            else if (st.escape_pending)
            begin
                st.error_seen = 1'b1;
                bd = add_result(bd, qat_pkg::KIND_ESC, 8'h00, st.token_count);
            end
            else if (st.inside_token)
            begin
                st.inside_token  = 1'b0;
                st.inside_quotes = 1'b0;
                if (st.token_count != 16'hFFFF)
                    st.token_count = st.token_count + 16'd1;
                bd = add_result(bd, qat_pkg::KIND_END, 8'h00, st.token_count);
            end
        end

        st_next = string_last ? '0 : st;
        bundle  = bd;
    end

    // tokenizer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (in_fire)
            st_reg <= st_next;
    end

    // every string starts from a clean state
    `QAT_ASSERT_NEXT(a_front_clear_after_last, in_fire && string_last, st_reg == '0, "front state not cleared after final byte")

endmodule

@@ design/qat_fifo.sv @@
// ----------------------------------------------------------------------------
// qat_fifo
// short queue of result bundles between classifier and serializer
// ----------------------------------------------------------------------------
`include "quoted_argument_tokenizer_top_macros.svh"

module qat_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  qat_pkg::bundle_t  wr_data,
    input  logic              rd,
    output qat_pkg::bundle_t  rd_data,
    output logic              full,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qat_pkg::bundle_t mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // bundle storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    `QAT_ASSERT_ALWAYS(a_fifo_count_range, count_reg <= CW'(DEPTH), "queue count out of range")
    `QAT_ASSERT_ALWAYS(a_fifo_no_overrun, !(wr && full), "bundle written while queue full")

endmodule

@@ design/qat_back.sv @@
// ----------------------------------------------------------------------------
// qat_back
// walks each bundle one result at a time into the output register
// ----------------------------------------------------------------------------
`include "quoted_argument_tokenizer_top_macros.svh"

module qat_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  qat_pkg::bundle_t  head,
    input  logic              head_empty,
    output logic              head_pop,
    input  logic              pop,
    output logic              empty,
    output logic [2:0]        result_kind,
    output logic [7:0]        token_byte,
    output logic              run_last,
    output logic              string_done,
    output logic [15:0]       token_total
);

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [1:0]    sub_reg;
    logic [1:0]    sub_next;
    logic [2:0]    kind_reg;
    logic [7:0]    byte_reg;
    logic          run_last_reg;
    logic          done_reg;
    logic [15:0]   total_reg;
    logic          take;
    logic          load;
    logic          fin;
    qat_pkg::kind_t cur_kind;

    assign take     = pop && out_valid_reg;
    assign load     = (!out_valid_reg || take) && !head_empty;
    assign fin      = ((sub_reg + 2'd1) == head.cnt);
    assign cur_kind = head.kind[sub_reg];
    assign head_pop = load && fin;

    // serializer control
    always_comb
    begin
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            sub_next       = fin ? 2'd0 : sub_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg     <= cur_kind;
            byte_reg     <= head.tbyte[sub_reg];
            total_reg    <= head.total[sub_reg];
            run_last_reg <= fin;
            done_reg     <= (cur_kind == qat_pkg::KIND_BADQ) ||
                            (cur_kind == qat_pkg::KIND_OPENQ) ||
                            (cur_kind == qat_pkg::KIND_ESC) ||
                            (fin && head.last);
        end
    end

    assign empty       = !out_valid_reg;
    assign result_kind = kind_reg;
    assign token_byte  = byte_reg;
    assign run_last    = run_last_reg;
    assign string_done = done_reg;
    assign token_total = total_reg;

    `QAT_ASSERT_ALWAYS(a_back_sub_in_range, head_empty || (sub_reg < head.cnt), "result index beyond bundle size")
    `QAT_ASSERT_ALWAYS(a_back_pop_nonempty, !(head_pop && head_empty), "bundle popped from empty queue")

endmodule

@@ design/quoted_argument_tokenizer_top.sv @@
// Each accepted byte's bundle is queued, then loaded result by result into the output
// register. Throughput: one byte per cycle in while the queue is not full; one result
// per cycle out while pop is held, so a byte causing n results yields n output words
// while the bundle queue absorbs the rest. Bytes causing no result are not queued.
// Reset: rst_n clears all tokenizer flags, the token counter and the queue at once.
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_top
// shell-style argument tokenizer: classifier, bundle queue and serializer
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer_top
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  text_byte,
    input  logic        string_last,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  result_kind,
    output logic [7:0]  token_byte,
    output logic        run_last,
    output logic        string_done,
    output logic [15:0] token_total
);

    qat_pkg::bundle_t front_bundle;
    qat_pkg::bundle_t head_bundle;
    logic             in_fire;
    logic             q_wr;
    logic             q_empty;
    logic             q_pop;

    assign in_fire = push && !full;
    assign q_wr    = in_fire && (front_bundle.cnt != 2'd0);

    // byte classifier
    qat_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .text_byte   (text_byte),
        .string_last (string_last),
        .bundle      (front_bundle)
    );

    // bundle queue
    qat_fifo #(.DEPTH(DEPTH)) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (front_bundle),
        .rd      (q_pop),
        .rd_data (head_bundle),
        .full    (full),
        .empty   (q_empty)
    );

    // result serializer
    qat_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_bundle),
        .head_empty  (q_empty),
        .head_pop    (q_pop),
        .pop         (pop),
        .empty       (empty),
        .result_kind (result_kind),
        .token_byte  (token_byte),
        .run_last    (run_last),
        .string_done (string_done),
        .token_total (token_total)
    );

endmodule

@@ tb/quoted_argument_tokenizer_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_top_tb
// Streams command strings into the tokenizer and checks every result word
// against a behavioral tokenizer kept in the testbench. A short table of
// hand-picked words comes first, then a back-pressure burst and random
// strings (mostly well formed, some broken, some noise), most of them with
// random gaps on both sides.
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer_top_tb;

    localparam int          RANDOM_WORDS = 290;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int          N_DIRECTED   = 27;

    // short names for the character and kind codes
    localparam logic [7:0] C_SP  = qat_pkg::CH_SPACE;
    localparam logic [7:0] C_TAB = qat_pkg::CH_TAB;
    localparam logic [7:0] C_LF  = qat_pkg::CH_LF;
    localparam logic [7:0] C_SQ  = qat_pkg::CH_SQUOTE;
    localparam logic [7:0] C_DQ  = qat_pkg::CH_DQUOTE;
    localparam logic [7:0] C_BS  = qat_pkg::CH_BSLASH;

    localparam qat_pkg::kind_t K_BYTE  = qat_pkg::KIND_BYTE;
    localparam qat_pkg::kind_t K_END   = qat_pkg::KIND_END;
    localparam qat_pkg::kind_t K_BADQ  = qat_pkg::KIND_BADQ;
    localparam qat_pkg::kind_t K_OPENQ = qat_pkg::KIND_OPENQ;
    localparam qat_pkg::kind_t K_ESC   = qat_pkg::KIND_ESC;

    // one expected result word
    typedef struct packed {
        qat_pkg::kind_t kind;
        logic [7:0]     tbyte;
        logic           run_last;
        logic           string_done;
        logic [15:0]    total;
    } token_result_t;

    // one directed input word; typed rows also carry the last result it causes
    typedef struct packed {
        logic [7:0]     text;
        logic           last;
        logic           typed;
        qat_pkg::kind_t kind;
        logic [7:0]     tbyte;
        logic [15:0]    total;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  text_byte;
    logic        string_last;
    logic        empty;
    logic        pop;
    logic [2:0]  result_kind;
    logic [7:0]  token_byte;
    logic        run_last;
    logic        string_done;
    logic [15:0] token_total;

    // tokenizer state mirrored in the testbench
    logic        tok_open;
    logic        in_quotes;
    logic        dq_mode;
    logic        esc_pending;
    logic        bs_held;
    logic        err_latched;
    logic [15:0] tok_count;

    token_result_t step_results[$];
    token_result_t expected_results[$];
    logic [7:0]    text_q[$];

    int          error_count;
    int          words_sent;
    int          strings_sent;
    int          results_checked;
    int          kind_seen[5];
    logic [15:0] peak_total;
    bit          gaps_on;
    bit          hold_request;

    // directed words: extremes, quoting, escapes and every error kind
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{8'h61, 1'b0, 1'b1, K_BYTE,  8'h61, 16'd0},  // first word after reset
        '{8'hFF, 1'b1, 1'b1, K_END,   8'h00, 16'd1},  // top byte, then end of string
        '{8'h00, 1'b1, 1'b1, K_END,   8'h00, 16'd1},  // bottom byte alone
        '{C_DQ,  1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},  // open double quote
        '{C_TAB, 1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},  // tab kept inside quotes
        '{C_BS,  1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},  // backslash held
        '{C_DQ,  1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},  // escaped matching quote
        '{C_BS,  1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},
        '{C_LF,  1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},  // newline skipped while held
        '{C_DQ,  1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},
        '{C_BS,  1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},
        '{8'h78, 1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},  // held backslash released
        '{C_SQ,  1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},  // other quote is plain
        '{C_DQ,  1'b0, 1'b1, K_END,   8'h00, 16'd1},  // closing quote ends token
        '{C_BS,  1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},  // bare escape
        '{C_SP,  1'b0, 1'b1, K_BYTE,  C_SP,  16'd1},  // escaped blank opens token
        '{C_SQ,  1'b0, 1'b1, K_BADQ,  8'h00, 16'd1},  // quote in bare token
        '{8'h7A, 1'b1, 1'b0, K_BYTE,  8'h00, 16'd0},  // dropped after error
        '{C_SQ,  1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},
        '{C_BS,  1'b1, 1'b1, K_OPENQ, 8'h00, 16'd0},  // held backslash at end
        '{C_BS,  1'b1, 1'b1, K_ESC,   8'h00, 16'd0},  // dangling escape
        '{C_SQ,  1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},
        '{C_SQ,  1'b1, 1'b1, K_END,   8'h00, 16'd1},  // empty quoted token
        '{C_BS,  1'b0, 1'b0, K_BYTE,  8'h00, 16'd0},
        '{C_BS,  1'b0, 1'b1, K_BYTE,  C_BS,  16'd0},  // escaped backslash
        '{C_LF,  1'b1, 1'b1, K_END,   8'h00, 16'd1},  // newline as final word
        '{C_SP,  1'b1, 1'b0, K_BYTE,  8'h00, 16'd0}   // string with no result
    };

    quoted_argument_tokenizer_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .string_last (string_last),
        .empty       (empty),
        .pop         (pop),
        .result_kind (result_kind),
        .token_byte  (token_byte),
        .run_last    (run_last),
        .string_done (string_done),
        .token_total (token_total)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard limit on the run
    initial
    begin
        #10ms;
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------- tokenizer

    function void emit_result(input qat_pkg::kind_t k, input logic [7:0] b);
        token_result_t r;
        r.kind        = k;
        r.tbyte       = (k == K_BYTE) ? b : 8'h00;
        r.run_last    = 1'b0;
        r.string_done = 1'b0;
        r.total       = tok_count;
        step_results.insert(step_results.size(), r);
    endfunction

    function void close_token();
        tok_open  = 1'b0;
        in_quotes = 1'b0;
        if (tok_count != 16'hFFFF)
            tok_count = tok_count + 16'd1;
        emit_result(K_END, 8'h00);
    endfunction

    function void raise_error(input qat_pkg::kind_t k);
        err_latched = 1'b1;
        emit_result(k, 8'h00);
    endfunction

    function void append_escaped(input logic [7:0] b);
        esc_pending = 1'b0;
        tok_open    = 1'b1;
        emit_result(K_BYTE, b);
    endfunction

    function void clear_string_state();
        tok_open    = 1'b0;
        in_quotes   = 1'b0;
        dq_mode     = 1'b0;
        esc_pending = 1'b0;
        bs_held     = 1'b0;
        err_latched = 1'b0;
        tok_count   = 16'd0;
    endfunction

    // one byte through the splitter, after any held backslash is settled
    function void classify_byte(input logic [7:0] b);
        logic [7:0] quote_ch;
        quote_ch = dq_mode ? C_DQ : C_SQ;
        if (b == C_SP || b == C_TAB)
        begin
            if (esc_pending)
                append_escaped(b);
            else if (tok_open)
            begin
                if (in_quotes)
                    emit_result(K_BYTE, b);
                else
                    close_token();
            end
        end
        else if (b == C_SQ || b == C_DQ)
        begin
            if (esc_pending)
                append_escaped(b);
            else if (!tok_open)
            begin
                tok_open  = 1'b1;
                in_quotes = 1'b1;
                dq_mode   = (b == C_DQ);
            end
            else if (in_quotes)
            begin
                if (b == quote_ch)
                    close_token();
                else
                    emit_result(K_BYTE, b);
            end
            else
                raise_error(K_BADQ);
        end
        else if (b == C_BS)
        begin
            if (in_quotes)
                bs_held = 1'b1;
            else if (esc_pending)
                append_escaped(b);
            else
                esc_pending = 1'b1;
        end
        else
            append_escaped(b);
    endfunction

    // results of one accepted word, appended to the expected results
    function void tokenize_byte(input logic [7:0] b, input logic last);
        logic [7:0] quote_ch;
        bit         consumed;
        token_result_t r;
        step_results.delete();
        consumed = 1'b0;
        if (!err_latched && b != C_LF)
        begin
            if (bs_held)
            begin
                quote_ch = dq_mode ? C_DQ : C_SQ;
                bs_held  = 1'b0;
                if (b == quote_ch)
                begin
                    emit_result(K_BYTE, b);
                    consumed = 1'b1;
                end
                else
                    emit_result(K_BYTE, C_BS);
            end
            if (!consumed)
                classify_byte(b);
        end
        // implied newline at the end of the string
        if (last && !err_latched)
        begin
            if (bs_held)
            begin
                bs_held = 1'b0;
                emit_result(K_BYTE, C_BS);
            end
            if (in_quotes)
                raise_error(K_OPENQ);
            else if (esc_pending)
                raise_error(K_ESC);
            else if (tok_open)
                close_token();
        end
        for (int k = 0; k < step_results.size(); k++)
        begin
            r = step_results[k];
            r.run_last    = (k == step_results.size() - 1);
            r.string_done = (r.kind >= K_BADQ) || (r.run_last && last);
            step_results[k] = r;
            expected_results.insert(expected_results.size(), r);
            kind_seen[int'(r.kind)]++;
            if (r.total > peak_total)
                peak_total = r.total;
        end
        if (last)
            clear_string_state();
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void put_text(input logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic int unsigned pause_length();
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] special_char();
        case ($urandom_range(0, 5))
            0: return C_SP;
            1: return C_TAB;
            2: return C_LF;
            3: return C_SQ;
            4: return C_DQ;
            default: return C_BS;
        endcase
    endfunction

    // any byte that is not a blank, newline, quote or backslash
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
        begin
            if ($urandom_range(0, 3) == 0)
                c = 8'($urandom_range(0, 255));
            else
                c = 8'($urandom_range(8'h61, 8'h7A));
        end
        while (c == C_SP || c == C_TAB || c == C_LF || c == C_SQ ||
               c == C_DQ || c == C_BS);
        return c;
    endfunction

    function automatic void add_blanks();
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
            put_text(($urandom_range(0, 2) == 0) ? C_TAB : C_SP);
    endfunction

    // one well-formed token: bare with escapes, or single or double quoted
    function automatic void add_token();
        int         style;
        int         n;
        int unsigned r;
        logic [7:0] q;
        style = $urandom_range(0, 2);
        if (style == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    put_text(C_BS);
                    put_text(($urandom_range(0, 1) == 0) ? special_char() :
                             8'($urandom_range(0, 255)));
                end
                else
                    put_text(plain_char());
            end
        end
        else
        begin
            q = (style == 1) ? C_SQ : C_DQ;
            put_text(q);
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    put_text(($urandom_range(0, 1) == 0) ? C_TAB : C_SP);
                else if (r < 20)
                    put_text((q == C_SQ) ? C_DQ : C_SQ);
                else if (r < 32)
                begin
                    put_text(C_BS);
                    if ($urandom_range(0, 3) == 0)
                        put_text(C_LF);
                    put_text(($urandom_range(0, 1) == 0) ? q : plain_char());
                end
                else
                    put_text(plain_char());
            end
            put_text(q);
        end
        if ($urandom_range(0, 19) == 0)
            put_text(C_LF);
    endfunction

    // one random command string: well formed, broken at the end, or noise
    function automatic void build_string();
        int unsigned mode;
        int          n;
        text_q.delete();
        mode = $urandom_range(0, 99);
        if (mode < 80)
        begin
            if ($urandom_range(0, 3) == 0)
                add_blanks();
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
            begin
                if (i != 0)
                    add_blanks();
                add_token();
            end
            if ($urandom_range(0, 3) == 0)
                add_blanks();
            // broken endings
            if (mode >= 65)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        put_text(C_SP);
                        put_text(($urandom_range(0, 1) == 0) ? C_SQ : C_DQ);
                        put_text(plain_char());
                    end
                    1: put_text(C_BS);
                    default:
                    begin
                        put_text(C_SP);
                        put_text(plain_char());
                        put_text(($urandom_range(0, 1) == 0) ? C_SQ : C_DQ);
                        put_text(plain_char());
                        put_text(C_SP);
                        put_text(plain_char());
                    end
                endcase
            end
        end
        else
        begin
            n = $urandom_range(1, 10);
            repeat (n)
                put_text(($urandom_range(0, 1) == 0) ? special_char() :
                         8'($urandom_range(0, 255)));
        end
    endfunction

    // offer one word and wait until it is taken
    task automatic send_word(input logic [7:0] b, input logic last);
        push        <= 1'b1;
        text_byte   <= b;
        string_last <= last;
        do
            @(posedge clk);
        while (full);
        tokenize_byte(b, last);
        words_sent++;
        if (last)
            strings_sent++;
    endtask

    task automatic sender_pause();
        int unsigned n;
        n = pause_length();
        if (n != 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_string();
        for (int i = 0; i < text_q.size(); i++)
        begin
            sender_pause();
            send_word(text_q[i], i == text_q.size() - 1);
        end
    endtask

    // ---------------------------------------------------------------- checking

    function void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            error_count++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endfunction

    function void check_result();
        token_result_t want;
        if (expected_results.size() == 0)
        begin
            error_count++;
            $error("unexpected result word: kind %0d byte %0d", result_kind, token_byte);
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        check_field("result_kind", int'(want.kind), int'(result_kind));
        check_field("token_byte", int'(want.tbyte), int'(token_byte));
        check_field("run_last", int'(want.run_last), int'(run_last));
        check_field("string_done", int'(want.string_done), int'(string_done));
        check_field("token_total", int'(want.total), int'(token_total));
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned stall_left;
        int unsigned n;
        stall_left = 0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                check_result();
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                n = pause_length();
                if (n == 0)
                    pop <= 1'b1;
                else
                begin
                    stall_left = n - 1;
                    pop <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- main flow

    initial
    begin
        int random_words;
        push         <= 1'b0;
        text_byte    <= 8'h00;
        string_last  <= 1'b0;
        rst_n        <= 1'b0;
        error_count  = 0;
        words_sent   = 0;
        strings_sent = 0;
        random_words = 0;
        results_checked = 0;
        peak_total   = 16'd0;
        hold_request = 1'b0;
        gaps_on      = 1'b1;
        foreach (kind_seen[k])
            kind_seen[k] = 0;
        clear_string_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; typed rows also cross-check the last predicted result
        foreach (directed_rows[i])
        begin
            sender_pause();
            send_word(directed_rows[i].text, directed_rows[i].last);
            if (directed_rows[i].typed)
            begin
                if (step_results.size() == 0 ||
                    step_results[$].kind  != directed_rows[i].kind  ||
                    step_results[$].tbyte != directed_rows[i].tbyte ||
                    step_results[$].total != directed_rows[i].total)
                begin
                    error_count++;
                    $error("directed row %0d: tokenizer outcome differs from table", i);
                end
            end
        end

        // back-pressure: result side holds off while words keep coming
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        text_q.delete();
        for (int i = 0; i < 40; i++)
            put_text((i % 3 == 2) ? C_SP : 8'(8'h61 + i % 26));
        send_string();

        // random strings, some with and some without gaps
        while (random_words < RANDOM_WORDS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            build_string();
            random_words += text_q.size();
            send_string();
        end
        gaps_on = 1'b1;
        push <= 1'b0;

        // drain
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("sent %0d words in %0d strings, checked %0d results, peak token count %0d",
                 words_sent, strings_sent, results_checked, peak_total);
        $display("results by kind: byte %0d, end %0d, bad quote %0d, unclosed %0d, escape %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/qat_pkg.sv
design/qat_front.sv
design/qat_fifo.sv
design/qat_back.sv
design/quoted_argument_tokenizer_top.sv
tb/quoted_argument_tokenizer_top_tb.sv
